[rtl/net_pkg.sv]
// Package: shared types, codes and reset values of the neighbour edge table.
package net_pkg;

  localparam int EDGE_SLOTS_DEF = 64;
  localparam int NODE_SLOTS_DEF = 32;
  localparam int MAX_DEAD       = 32;
  localparam int DEAD_CW        = $clog2(MAX_DEAD + 1);
  localparam int DEAD_IW        = $clog2(MAX_DEAD);

  localparam logic [1:0] OP_PING   = 2'd0;
  localparam logic [1:0] OP_STAMP  = 2'd1;
  localparam logic [1:0] OP_SWEEP  = 2'd2;
  localparam logic [1:0] OP_IGNORE = 2'd3;

  localparam logic [1:0] REG_CONNECT    = 2'd0;
  localparam logic [1:0] REG_DISCONNECT = 2'd1;
  localparam logic [1:0] REG_LIMIT      = 2'd2;
  localparam logic [1:0] REG_LIFESPAN   = 2'd3;

  localparam logic signed [7:0] CONNECT_RST    = -8'sd80;
  localparam logic signed [7:0] DISCONNECT_RST = -8'sd90;
  localparam logic [6:0]        LIMIT_RST      = 7'd4;
  localparam logic [31:0]       LIFESPAN_RST   = 32'd10000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_E_FIND,
    ST_E_WRITE,
    ST_P_DROP,
    ST_P_CHECK,
    ST_P_WEAK,
    ST_P_CLEAR,
    ST_N_FIND,
    ST_N_WRITE,
    ST_S_NODE,
    ST_S_EDGE,
    ST_EMIT
  } state_t;

endpackage

[rtl/neighbour_edge_table_top.sv]
// Top level: neighbour edge table with edge and node memories and a scan sequencer.
// Ping: scan edges, write, drop own edges below the disconnect threshold, then drop the
// weakest own edge while over the limit. Stamp: scan nodes, write. Sweep: scan nodes,
// then edges, then one beat per cycle per dead node unless m_tready stalls. One item at
// a time; every scan walks a memory read port one entry per cycle. Reset clears all
// valid bits at once (no clearing pass) and loads the register defaults.
module neighbour_edge_table_top #(
  parameter int EDGE_SLOTS = net_pkg::EDGE_SLOTS_DEF,
  parameter int NODE_SLOTS = net_pkg::NODE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // from_node, to_node, strength, now_ms
  input  logic [1:0]  s_tuser,  // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // new_edge, table_full, dead_valid, dead_node, pad
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int EAW = $clog2(EDGE_SLOTS);
  localparam int NAW = $clog2(NODE_SLOTS);
  localparam int SW  = (EAW > NAW) ? EAW : NAW;
  localparam int CW  = $clog2(EDGE_SLOTS + 1);
  localparam logic [SW-1:0] ELAST = SW'(EDGE_SLOTS - 1);
  localparam logic [SW-1:0] NLAST = SW'(NODE_SLOTS - 1);

  net_pkg::state_t state, state_next;

  logic signed [7:0] connect_threshold, disconnect_threshold;
  logic [6:0]        neighbour_limit;
  logic [31:0]       silence_limit;

  logic [39:0] emem [EDGE_SLOTS];
  logic [47:0] nmem [NODE_SLOTS];
  logic [39:0] ed;
  logic [47:0] nd;
  logic        evld [EDGE_SLOTS];
  logic        nvld [NODE_SLOTS];

  logic [SW-1:0] ra, ri, scan_last;
  logic          scan_on, rv;

  logic [1:0]        op_q;
  logic [15:0]       from_q, to_q;
  logic signed [7:0] str_q;
  logic [31:0]       now_q;

  logic          found, free_ok, added, full, weak_ok;
  logic [SW-1:0] found_idx, free_idx, weak_idx;
  logic signed [7:0] weak_str;
  logic [CW-1:0] cnt;

  logic [15:0]               dead [net_pkg::MAX_DEAD];
  logic [net_pkg::DEAD_CW-1:0] ndead;
  logic [net_pkg::DEAD_IW-1:0] eidx;

  logic          s_acc, scan_done, out_free, scan_start, dead_hit, emit_last;
  logic [SW-1:0] scan_last_in;
  logic          e_we, n_we, cfg_we;
  logic [SW-1:0] e_wa, n_wa;

  logic [15:0]       e_src, e_dst, n_node;
  logic signed [7:0] e_str;
  logic [31:0]       n_stamp, n_age;
  logic              e_live, e_own, n_live;

  assign s_acc     = s_tvalid && s_tready;
  assign scan_done = rv && (ri == scan_last);
  assign out_free  = !m_tvalid || m_tready;
  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite;

  assign e_src   = ed[15:0];
  assign e_dst   = ed[31:16];
  assign e_str   = $signed(ed[39:32]);
  assign n_node  = nd[15:0];
  assign n_stamp = nd[47:16];
  assign n_age   = now_q - n_stamp;
  assign e_live  = evld[ri[EAW-1:0]];
  assign n_live  = nvld[ri[NAW-1:0]];
  assign e_own   = e_live && (e_src == from_q);
  assign emit_last = (ndead == net_pkg::DEAD_CW'(eidx) + 1'b1);

  always_comb begin
    dead_hit = 1'b0;
    for (int k = 0; k < net_pkg::MAX_DEAD; k++) begin
      if ((net_pkg::DEAD_CW'(k) < ndead) && ((e_src == dead[k]) || (e_dst == dead[k]))) begin
        dead_hit = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      net_pkg::ST_IDLE: begin
        if (s_acc) begin
          unique case (s_tuser)
            net_pkg::OP_PING:  state_next = net_pkg::ST_E_FIND;
            net_pkg::OP_STAMP: state_next = net_pkg::ST_N_FIND;
            net_pkg::OP_SWEEP: state_next = net_pkg::ST_S_NODE;
            default:           state_next = net_pkg::ST_EMIT;
          endcase
        end
      end
      net_pkg::ST_E_FIND:  if (scan_done) state_next = net_pkg::ST_E_WRITE;
      net_pkg::ST_E_WRITE: state_next = net_pkg::ST_P_DROP;
      net_pkg::ST_P_DROP:  if (scan_done) state_next = net_pkg::ST_P_CHECK;
      net_pkg::ST_P_CHECK: begin
        if (cnt > CW'(neighbour_limit)) state_next = net_pkg::ST_P_WEAK;
        else state_next = net_pkg::ST_EMIT;
      end
      net_pkg::ST_P_WEAK:  if (scan_done) state_next = net_pkg::ST_P_CLEAR;
      net_pkg::ST_P_CLEAR: begin
        if (weak_ok) state_next = net_pkg::ST_P_CHECK;
        else state_next = net_pkg::ST_EMIT;
      end
      net_pkg::ST_N_FIND:  if (scan_done) state_next = net_pkg::ST_N_WRITE;
      net_pkg::ST_N_WRITE: state_next = net_pkg::ST_EMIT;
      net_pkg::ST_S_NODE:  if (scan_done) state_next = net_pkg::ST_S_EDGE;
      net_pkg::ST_S_EDGE:  if (scan_done) state_next = net_pkg::ST_EMIT;
      net_pkg::ST_EMIT: begin
        if (out_free && ((op_q != net_pkg::OP_SWEEP) || (ndead == '0) || emit_last)) begin
          state_next = net_pkg::ST_IDLE;
        end
      end
      default: state_next = net_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = (state == net_pkg::ST_IDLE);
    scan_start   = 1'b0;
    scan_last_in = ELAST;
    e_we         = 1'b0;
    e_wa         = found ? found_idx : free_idx;
    n_we         = 1'b0;
    n_wa         = found ? found_idx : free_idx;
    unique case (state)
      net_pkg::ST_IDLE: begin
        if (s_acc && (s_tuser != net_pkg::OP_IGNORE)) begin
          scan_start = 1'b1;
          if (s_tuser != net_pkg::OP_PING) scan_last_in = NLAST;
        end
      end
      net_pkg::ST_E_WRITE: begin
        scan_start = 1'b1;
        e_we = found || ((str_q >= connect_threshold) && free_ok);
      end
      net_pkg::ST_P_CHECK: scan_start = (cnt > CW'(neighbour_limit));
      net_pkg::ST_N_WRITE: n_we = found || free_ok;
      net_pkg::ST_S_NODE:  scan_start = scan_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (e_we) emem[e_wa[EAW-1:0]] <= {str_q, to_q, from_q};
    ed <= emem[ra[EAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (n_we) nmem[n_wa[NAW-1:0]] <= {now_q, from_q};
    nd <= nmem[ra[NAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      connect_threshold    <= net_pkg::CONNECT_RST;
      disconnect_threshold <= net_pkg::DISCONNECT_RST;
      neighbour_limit      <= net_pkg::LIMIT_RST;
      silence_limit        <= net_pkg::LIFESPAN_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        net_pkg::REG_CONNECT:    connect_threshold    <= $signed(pwdata[7:0]);
        net_pkg::REG_DISCONNECT: disconnect_threshold <= $signed(pwdata[7:0]);
        net_pkg::REG_LIMIT:      neighbour_limit      <= pwdata[6:0];
        net_pkg::REG_LIFESPAN:   silence_limit        <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      net_pkg::REG_CONNECT:    prdata = {{24{connect_threshold[7]}}, connect_threshold};
      net_pkg::REG_DISCONNECT: prdata = {{24{disconnect_threshold[7]}}, disconnect_threshold};
      net_pkg::REG_LIMIT:      prdata = {25'd0, neighbour_limit};
      net_pkg::REG_LIFESPAN:   prdata = silence_limit;
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= net_pkg::ST_IDLE;
      scan_on  <= 1'b0;
      rv       <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < EDGE_SLOTS; i++) evld[i] <= 1'b0;
      for (int i = 0; i < NODE_SLOTS; i++) nvld[i] <= 1'b0;
    end else begin
      state <= state_next;
      rv    <= scan_on;
      ri    <= ra;
      if (scan_start) begin
        ra        <= '0;
        scan_on   <= 1'b1;
        scan_last <= scan_last_in;
      end else if (scan_on) begin
        if (ra == scan_last) scan_on <= 1'b0;
        else ra <= ra + 1'b1;
      end
      if (m_tvalid && m_tready && !((state == net_pkg::ST_EMIT) && out_free)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        net_pkg::ST_IDLE: begin
          if (s_acc) begin
            op_q    <= s_tuser;
            from_q  <= s_tdata[15:0];
            to_q    <= s_tdata[31:16];
            str_q   <= $signed(s_tdata[39:32]);
            now_q   <= s_tdata[71:40];
            found   <= 1'b0;
            free_ok <= 1'b0;
            added   <= 1'b0;
            full    <= 1'b0;
            ndead   <= '0;
            eidx    <= '0;
          end
        end
        net_pkg::ST_E_FIND: begin
          if (rv) begin
            if (e_live) begin
              if (!found && (e_src == from_q) && (e_dst == to_q)) begin
                found     <= 1'b1;
                found_idx <= ri;
              end
            end else if (!free_ok) begin
              free_ok  <= 1'b1;
              free_idx <= ri;
            end
          end
        end
        net_pkg::ST_E_WRITE: begin
          cnt <= '0;
          if (!found && (str_q >= connect_threshold)) begin
            if (free_ok) begin
              evld[free_idx[EAW-1:0]] <= 1'b1;
              added <= 1'b1;
            end else begin
              full <= 1'b1;
            end
          end
        end
        net_pkg::ST_P_DROP: begin
          if (rv && e_own) begin
            if (e_str < disconnect_threshold) evld[ri[EAW-1:0]] <= 1'b0;
            else cnt <= cnt + 1'b1;
          end
        end
        net_pkg::ST_P_CHECK: weak_ok <= 1'b0;
        net_pkg::ST_P_WEAK: begin
          if (rv && e_own && (!weak_ok || (e_str < weak_str))) begin
            weak_ok  <= 1'b1;
            weak_idx <= ri;
            weak_str <= e_str;
          end
        end
        net_pkg::ST_P_CLEAR: begin
          if (weak_ok) begin
            evld[weak_idx[EAW-1:0]] <= 1'b0;
            cnt <= cnt - 1'b1;
          end
        end
        net_pkg::ST_N_FIND: begin
          if (rv) begin
            if (n_live) begin
              if (!found && (n_node == from_q)) begin
                found     <= 1'b1;
                found_idx <= ri;
              end
            end else if (!free_ok) begin
              free_ok  <= 1'b1;
              free_idx <= ri;
            end
          end
        end
        net_pkg::ST_N_WRITE: begin
          if (!found) begin
            if (free_ok) nvld[free_idx[NAW-1:0]] <= 1'b1;
            else full <= 1'b1;
          end
        end
        net_pkg::ST_S_NODE: begin
          if (rv && n_live && (ndead < net_pkg::DEAD_CW'(net_pkg::MAX_DEAD)) &&
              (n_age > silence_limit)) begin
            dead[ndead[net_pkg::DEAD_IW-1:0]] <= n_node;
            ndead <= ndead + 1'b1;
            nvld[ri[NAW-1:0]] <= 1'b0;
          end
        end
        net_pkg::ST_S_EDGE: begin
          if (rv && e_live && dead_hit) evld[ri[EAW-1:0]] <= 1'b0;
        end
        net_pkg::ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if ((op_q == net_pkg::OP_SWEEP) && (ndead != '0)) begin
              m_tdata <= {5'd0, dead[eidx], 1'b1, 1'b0, 1'b0};
              m_tlast <= emit_last;
              eidx    <= eidx + 1'b1;
            end else begin
              m_tdata <= {21'd0, full, added};
              m_tlast <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
